// ===== rtl/brtc_pkg.sv =====
// ----------------------------------------------------------------------------
// Blind relay timeout controller package
// Shared constants, command codes, request type and relay word mapping.
// ----------------------------------------------------------------------------
package brtc_pkg;

  localparam int CHANNELS = 8;
  localparam int MASK_W   = 8;
  localparam int TICK_W   = 16;
  localparam int WORD_W   = 16;

  localparam logic [TICK_W-1:0] ACTIVE_TICKS_RESET = TICK_W'(30 * 1000);

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_UP   = 2'd1,
    CMD_DOWN = 2'd2,
    CMD_STOP = 2'd3
  } cmd_t;

  typedef struct packed {
    logic                go;
    cmd_t                cmd;
    logic [CHANNELS-1:0] mask;
  } brtc_req_t;

  // Channels driven both ways are dropped, the board wiring swaps are applied
  // and the word is inverted because the relays are active low.
  function automatic logic [WORD_W-1:0] drive_word(input logic [7:0] up_bits,
                                                   input logic [7:0] down_bits);
    logic [7:0]        both;
    logic [WORD_W-1:0] t;
    logic [WORD_W-1:0] w;
    both  = up_bits & down_bits;
    t     = {down_bits & ~both, up_bits & ~both};
    w     = t;
    w[11] = t[8];
    w[8]  = t[11];
    w[9]  = t[10];
    w[10] = t[9];
    w[0]  = t[1];
    w[1]  = t[0];
    w[14] = t[6];
    w[6]  = t[14];
    return ~w;
  endfunction

endpackage

// ===== rtl/brtc_timer_bank.sv =====
// ----------------------------------------------------------------------------
// Blind relay timer bank
// Per-channel countdowns with arm flags; reports channels that expire on a tick.
// ----------------------------------------------------------------------------
module brtc_timer_bank import brtc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  brtc_req_t           req,
  input  logic [TICK_W-1:0]   active_ticks,
  output logic [CHANNELS-1:0] expiring
);

  logic [CHANNELS-1:0] armed_r;
  logic [CHANNELS-1:0] armed_nxt;
  logic [TICK_W-1:0]   count_r   [CHANNELS];
  logic [TICK_W-1:0]   count_nxt [CHANNELS];

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      expiring[i] = armed_r[i] && (count_r[i] <= TICK_W'(1));
    end
  end

  always_comb begin
    armed_nxt = armed_r;
    for (int i = 0; i < CHANNELS; i++) begin
      count_nxt[i] = count_r[i];
    end
    if (req.go) begin
      unique case (req.cmd)
        CMD_TICK: begin
          armed_nxt = armed_r & ~expiring;
          for (int i = 0; i < CHANNELS; i++) begin
            if (expiring[i]) begin
              count_nxt[i] = '0;
            end else if (armed_r[i]) begin
              count_nxt[i] = count_r[i] - TICK_W'(1);
            end
          end
        end
        CMD_UP, CMD_DOWN: begin
          armed_nxt = armed_r | req.mask;
          for (int i = 0; i < CHANNELS; i++) begin
            if (req.mask[i]) begin
              count_nxt[i] = active_ticks;
            end
          end
        end
        CMD_STOP: begin
          armed_nxt = armed_r & ~req.mask;
        end
        default: begin
          armed_nxt = armed_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= '0;
    end else begin
      armed_r <= armed_nxt;
    end
    for (int i = 0; i < CHANNELS; i++) begin
      count_r[i] <= count_nxt[i];
    end
  end

endmodule

// ===== rtl/blind_relay_timeout_controller.sv =====
// ----------------------------------------------------------------------------
// Blind relay timeout controller
// Drives the up and down relays of the roller blinds with automatic timeout.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output is not stalled
// and returns one result for each item: the item is held in the input register
// and its result in the result register, with the relay state and all channel
// timers updated as the item moves from one to the other. A stalled result holds
// the input side only once the input register is also full.
module blind_relay_timeout_controller import brtc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] channel_mask
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] relay_word
  output logic        out_tuser,  // [0] latched
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // [15:0] active_ticks
);

  logic                s1_valid_r;
  cmd_t                s1_cmd_r;
  logic [CHANNELS-1:0] s1_mask_r;
  logic [TICK_W-1:0]   active_ticks_r;
  logic [CHANNELS-1:0] up_r;
  logic [CHANNELS-1:0] up_nxt;
  logic [CHANNELS-1:0] down_r;
  logic [CHANNELS-1:0] down_nxt;
  logic                latched_nxt;
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_data_r;
  logic                out_user_r;
  logic                advance;
  logic [CHANNELS-1:0] expiring;
  brtc_req_t           req;

  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign req.go   = advance;
  assign req.cmd  = s1_cmd_r;
  assign req.mask = s1_mask_r;

  brtc_timer_bank u_timers (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req),
    .active_ticks (active_ticks_r),
    .expiring     (expiring)
  );

  always_comb begin
    up_nxt      = up_r;
    down_nxt    = down_r;
    latched_nxt = 1'b1;
    unique case (s1_cmd_r)
      CMD_TICK: begin
        up_nxt      = up_r & ~expiring;
        down_nxt    = down_r & ~expiring;
        latched_nxt = |expiring;
      end
      CMD_UP: begin
        up_nxt   = up_r | s1_mask_r;
        down_nxt = down_r & ~s1_mask_r;
      end
      CMD_DOWN: begin
        up_nxt   = up_r & ~s1_mask_r;
        down_nxt = down_r | s1_mask_r;
      end
      CMD_STOP: begin
        up_nxt   = up_r & ~s1_mask_r;
        down_nxt = down_r & ~s1_mask_r;
      end
      default: begin
        latched_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      up_r           <= '0;
      down_r         <= '0;
      active_ticks_r <= ACTIVE_TICKS_RESET;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        up_r        <= up_nxt;
        down_r      <= down_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        active_ticks_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r  <= cmd_t'(in_tuser);
      s1_mask_r <= in_tdata[CHANNELS-1:0];
    end
    if (advance) begin
      out_data_r <= drive_word(8'(up_nxt), 8'(down_nxt));
      out_user_r <= latched_nxt;
    end
  end

`ifndef SYNTHESIS
  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_cmd_r == CMD_STOP |=> ((up_r | down_r) & $past(s1_mask_r)) == '0)
    else $error("stop left a selected channel driven");

  a_cmd_latches: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_cmd_r != CMD_TICK |=> out_valid_r && out_user_r)
    else $error("move or stop command did not latch");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with an empty input register");

  a_tick_expiry_drops: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_cmd_r == CMD_TICK |=> ((up_r | down_r) & $past(expiring)) == '0)
    else $error("expired channel still driven");
`endif

endmodule

// ===== verif/tb_blind_relay_timeout_controller.sv =====
// ----------------------------------------------------------------------------
// Blind relay timeout controller testbench
// Sends move, stop and tick items over the input stream and checks every
// relay drive word and latch flag against a cycle-free model of the relays
// and channel timers. Several timeout settings are loaded between phases,
// and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_blind_relay_timeout_controller;
  import brtc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 80;
  localparam int EXP_DEPTH    = 64;

  typedef enum logic {
    RX_ALWAYS,
    RX_PATTERN
  } rx_mode_t;

  typedef struct packed {
    logic [15:0] relay_word;
    logic        latched;
  } relay_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [1:0]  in_tuser   = CMD_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = '0;

  logic [15:0] ticks_cfg = ACTIVE_TICKS_RESET;
  logic [7:0]  up_relays = '0;
  logic [7:0]  dn_relays = '0;
  logic [7:0]  armed_chans = '0;
  logic [15:0] chan_timer [CHANNELS];

  // Expected results in order, kept in a ring with free-running counters.
  relay_result_t expected_relays [EXP_DEPTH];
  int            exp_wr = 0;
  int            exp_rd = 0;

  int       mismatch_cnt = 0;
  int       stall_cycles = 0;
  int       burst_left   = 0;
  bit       pace_on      = 1'b0;
  rx_mode_t rx_mode      = RX_ALWAYS;
  int       hold_req     = 0;
  int       hold_ack     = 0;
  int       hold_left    = 0;
  logic [31:0] rx_pattern = '1;
  int       rx_pos       = 0;

  blind_relay_timeout_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [15:0] relay_drive(input logic [7:0] up, input logic [7:0] dn);
    logic [7:0]  both;
    logic [15:0] w;
    both = up & dn;
    w = {dn & ~both, up & ~both};
    {w[11], w[8]}  = {w[8], w[11]};
    {w[9], w[10]}  = {w[10], w[9]};
    {w[0], w[1]}   = {w[1], w[0]};
    {w[14], w[6]}  = {w[6], w[14]};
    return ~w;
  endfunction

  function automatic void predict_relays(input cmd_t cmd, input logic [7:0] mask);
    logic [7:0]    expired;
    relay_result_t res;
    expired = '0;
    res.latched = 1'b1;
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (armed_chans[i]) begin
            if (chan_timer[i] <= 16'd1) begin
              chan_timer[i] = '0;
              expired[i] = 1'b1;
            end else begin
              chan_timer[i] = chan_timer[i] - 16'd1;
            end
          end
        end
        up_relays   &= ~expired;
        dn_relays   &= ~expired;
        armed_chans &= ~expired;
        res.latched = (expired != '0);
      end
      CMD_UP, CMD_DOWN: begin
        if (cmd == CMD_UP) begin
          dn_relays &= ~mask;
          up_relays |= mask;
        end else begin
          up_relays &= ~mask;
          dn_relays |= mask;
        end
        for (int i = 0; i < CHANNELS; i++) begin
          if (mask[i]) chan_timer[i] = ticks_cfg;
        end
        armed_chans |= mask;
      end
      default: begin
        up_relays   &= ~mask;
        dn_relays   &= ~mask;
        armed_chans &= ~mask;
      end
    endcase
    res.relay_word = relay_drive(up_relays, dn_relays);
    expected_relays[6'(exp_wr)] = res;
    exp_wr++;
  endfunction

  task automatic send_item(input cmd_t cmd, input logic [7:0] mask);
    if (pace_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= mask;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    predict_relays(cmd, mask);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_active_ticks(input logic [15:0] ticks);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    ticks_cfg = ticks;
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_STOP, 8'h00);
    send_item(CMD_UP, 8'h00);
  endtask

  task automatic test_moves_and_wiring();
    write_active_ticks(16'hFFFF);
    send_item(CMD_UP, 8'hFF);
    send_item(CMD_DOWN, 8'h0F);
    send_item(CMD_STOP, 8'hFF);
    send_item(CMD_UP, 8'h01);
    send_item(CMD_DOWN, 8'h02);
    send_item(CMD_UP, 8'h40);
    send_item(CMD_DOWN, 8'h48);
    send_item(CMD_UP, 8'hA4);
    send_item(CMD_DOWN, 8'h01);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_STOP, 8'h5A);
  endtask

  task automatic test_timer_expiry();
    write_active_ticks(16'd3);
    send_item(CMD_UP, 8'h0F);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_DOWN, 8'h03);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'h00);
    write_active_ticks(16'd1);
    send_item(CMD_DOWN, 8'hF0);
    send_item(CMD_TICK, 8'h00);
    write_active_ticks(16'd0);
    send_item(CMD_UP, 8'hAA);
    send_item(CMD_STOP, 8'h0A);
    send_item(CMD_TICK, 8'h00);
  endtask

  task automatic test_random_traffic(input int n_items, input logic [15:0] ticks,
                                     input rx_mode_t mode, input bit paced);
    cmd_t       cmd;
    logic [7:0] mask;
    int         pick;
    write_active_ticks(ticks);
    rx_mode <= mode;
    pace_on = paced;
    burst_left = 0;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 9);
      cmd = (pick < 5) ? CMD_TICK : (pick < 7) ? CMD_UP : (pick < 9) ? CMD_DOWN : CMD_STOP;
      case ($urandom_range(0, 7))
        0:       mask = 8'h01 << $urandom_range(0, 7);
        1:       mask = 8'hFF;
        2:       mask = 8'h00;
        default: mask = 8'($urandom_range(0, 255));
      endcase
      send_item(cmd, mask);
    end
    pace_on = 1'b0;
  endtask

  task automatic test_output_backpressure();
    write_active_ticks(16'd6);
    rx_mode <= RX_ALWAYS;
    hold_req <= hold_req + 1;
    for (int n = 0; n < 40; n++) begin
      send_item(cmd_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_mode == RX_ALWAYS) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= rx_pattern[0] | rx_pattern[1];
      rx_pos     <= (rx_pos == 31) ? 0 : rx_pos + 1;
      rx_pattern <= (rx_pos == 31) ? $urandom : {rx_pattern[0], rx_pattern[31:1]};
    end
  end

  always @(negedge clk) begin : check_result
    relay_result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (exp_wr == exp_rd) begin
        if (mismatch_cnt < 10) begin
          $display("ERROR: unexpected result relay_word=%h latched=%b", out_tdata, out_tuser);
        end
        mismatch_cnt++;
      end else begin
        want = expected_relays[6'(exp_rd)];
        exp_rd++;
        if (out_tdata !== want.relay_word || out_tuser !== want.latched) begin
          if (mismatch_cnt < 10) begin
            $display("ERROR: relay_word exp %h got %h, latched exp %b got %b",
                     want.relay_word, out_tdata, want.latched, out_tuser);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CHANNELS; i++) chan_timer[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_moves_and_wiring();
    test_timer_expiry();
    test_random_traffic(250, 16'd4, RX_PATTERN, 1'b1);
    test_random_traffic(250, 16'd13, RX_ALWAYS, 1'b0);
    test_random_traffic(150, 16'd1, RX_PATTERN, 1'b1);
    test_random_traffic(100, 16'hFFFF, RX_PATTERN, 1'b0);
    test_random_traffic(150, 16'($urandom_range(2, 30)), RX_PATTERN, 1'b1);
    test_output_backpressure();
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
